// ----- src/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and controller/datapath interface types for the
// sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int DEFAULT_MAX_SIZE = 512;
  localparam int CFG_W            = 10;
  localparam int PIX_W            = 8;
  localparam logic [CFG_W-1:0] SIZE_RESET = 10'd320;
  localparam int MIN_SIZE         = 3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take pixel, read line buffers, advance counters
    logic win;        // shift window, write line buffers
    logic grad;       // compute abs gradients
    logic sq;         // square both gradients
    logic sum;        // add squares, start root search
    logic root_step;  // one bit of the root search
    logic load_out;   // load the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic produce;    // centre is interior, a result follows
    logic root_last;  // last root bit in progress
    logic out_busy;   // output register holds an untaken result
  } status_t;

endpackage

// ----- src/sem_ctrl.sv -----
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencing state machine: one pixel at a time through read, window,
// gradient, square, sum, bit-serial root and output load; border pixels stop after the window.
// ----------------------------------------------------------------------------
module sem_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sem_pkg::status_t status_i,
  output sem_pkg::cmd_t    cmd_o
);
  import sem_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WIN  = 3'd1;
  localparam logic [2:0] ST_GRAD = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = status_i.produce ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/sem_datapath.sv -----
// ----------------------------------------------------------------------------
// sem_datapath
// Size register, raster counters, two line buffers, 3x3 window, gradient
// and magnitude arithmetic, output register.
// ----------------------------------------------------------------------------
module sem_datapath #(
  parameter int MAX_SIZE = sem_pkg::DEFAULT_MAX_SIZE,
  parameter int CW       = $clog2(MAX_SIZE)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [sem_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic [sem_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       frame_start_i,
  input  logic                       out_ready_i,
  input  sem_pkg::cmd_t              cmd_i,
  output sem_pkg::status_t           status_o,
  output logic                       out_valid_o,
  output logic [sem_pkg::PIX_W-1:0]  edge_value_o,
  output logic [CW-1:0]              out_column_o,
  output logic [CW-1:0]              out_row_o,
  output logic                       last_of_frame_o
);
  import sem_pkg::*;

  localparam int SW = CW + 1;
  localparam int XW = (SW > CFG_W) ? SW : CFG_W;

  logic [CFG_W-1:0] size_cfg_q;
  logic [XW-1:0]    cfg_x;
  logic [SW-1:0]    size;

  logic [CW-1:0] col_cnt_q, row_cnt_q, col_cnt_d, row_cnt_d;
  logic [CW-1:0] base_col, base_row, col_use;
  logic [SW-1:0] nxt_col, nxt_row;
  logic [CW-1:0] col_q, row_q;
  logic [PIX_W-1:0] px_q;

  logic [PIX_W-1:0] lb0 [MAX_SIZE];
  logic [PIX_W-1:0] lb1 [MAX_SIZE];
  logic [PIX_W-1:0] lb0_rd_q, lb1_rd_q;
  logic [PIX_W-1:0] win_q [3][3];

  logic [9:0]  pos_x, neg_x, pos_y, neg_y;
  logic [10:0] dx, dy;
  logic [9:0]  gx_q, gy_q;
  logic [19:0] sqx_q, sqy_q;
  logic [20:0] sum_q;
  logic [7:0]  root_q, root_try;
  logic [15:0] try_sq;
  logic [2:0]  it_q;

  logic             out_valid_q, last_q;
  logic [PIX_W-1:0] edge_q;
  logic [CW-1:0]    ocol_q, orow_q;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      size_cfg_q <= cfg_data_i;
    end
  end

  // clamp size to the supported range
  always_comb begin
    cfg_x = XW'(size_cfg_q);
    if (cfg_x < XW'(MIN_SIZE)) size = SW'(MIN_SIZE);
    else if (cfg_x > XW'(MAX_SIZE)) size = SW'(MAX_SIZE);
    else size = SW'(cfg_x);
  end

  // raster position for the incoming pixel and counter advance
  always_comb begin
    base_col  = frame_start_i ? '0 : col_cnt_q;
    base_row  = frame_start_i ? '0 : row_cnt_q;
    col_use   = (SW'(base_col) >= size) ? '0 : base_col;
    nxt_col   = SW'(base_col) + SW'(1);
    nxt_row   = SW'(base_row) + SW'(1);
    col_cnt_d = CW'(nxt_col);
    row_cnt_d = base_row;
    if (nxt_col >= size) begin
      col_cnt_d = '0;
      row_cnt_d = (nxt_row >= size) ? '0 : CW'(nxt_row);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // captured transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q <= col_use;
      row_q <= base_row;
      px_q  <= pixel_i;
    end
  end

  // line buffers: read on accept, write back on window update
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lb0_rd_q <= lb0[col_use];
      lb1_rd_q <= lb1[col_use];
    end
    if (cmd_i.win) begin
      lb0[col_q] <= px_q;
      lb1[col_q] <= lb0_rd_q;
    end
  end

  // 3x3 window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '{default: '0};
    end else if (cmd_i.win) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= lb1_rd_q;
      win_q[1][2] <= lb0_rd_q;
      win_q[2][2] <= px_q;
    end
  end

  // interior test for the current centre
  assign status_o.produce = (row_q >= CW'(2)) && (SW'(row_q) < size) && (col_q >= CW'(2));

  // sobel sums
  always_comb begin
    pos_x = 10'(win_q[0][2]) + {1'b0, win_q[1][2], 1'b0} + 10'(win_q[2][2]);
    neg_x = 10'(win_q[0][0]) + {1'b0, win_q[1][0], 1'b0} + 10'(win_q[2][0]);
    pos_y = 10'(win_q[2][0]) + {1'b0, win_q[2][1], 1'b0} + 10'(win_q[2][2]);
    neg_y = 10'(win_q[0][0]) + {1'b0, win_q[0][1], 1'b0} + 10'(win_q[0][2]);
    dx    = {1'b0, pos_x} - {1'b0, neg_x};
    dy    = {1'b0, pos_y} - {1'b0, neg_y};
  end

  // gradient, square and sum stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q <= dx[10] ? 10'(-dx) : dx[9:0];
      gy_q <= dy[10] ? 10'(-dy) : dy[9:0];
    end
    if (cmd_i.sq) begin
      sqx_q <= gx_q * gx_q;
      sqy_q <= gy_q * gy_q;
    end
    if (cmd_i.sum) begin
      sum_q <= 21'(sqx_q) + 21'(sqy_q);
    end
  end

  // bit-serial integer square root, msb first
  assign root_try = root_q | (8'd1 << it_q);
  assign try_sq   = root_try * root_try;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.sum) begin
      it_q <= 3'd7;
    end else if (cmd_i.root_step) begin
      it_q <= it_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      root_q <= '0;
    end else if (cmd_i.root_step && (21'(try_sq) <= sum_q)) begin
      root_q <= root_try;
    end
  end

  assign status_o.root_last = (it_q == 3'd0);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      edge_q <= (sum_q[20:16] != 5'd0) ? 8'hFF : root_q;
      ocol_q <= col_q - CW'(1);
      orow_q <= row_q - CW'(1);
      last_q <= (SW'(row_q) == size - SW'(1)) && (SW'(col_q) == size - SW'(1));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign edge_value_o    = edge_q;
  assign out_column_o    = ocol_q;
  assign out_row_o       = orow_q;
  assign last_of_frame_o = last_q;

endmodule

// ----- src/sobel_edge_magnitude_top.sv -----
// result path: an interior pixel goes through window, gradient, square and
// sum, the 8-step bit-serial square root and the output load, which waits
// while the output register is not taken; border pixels give no result
// throughput: a new pixel is taken only when the last one is through
// reset: counters, window, size (320) and valid flags clear at once; line
// buffers are not cleared and are always written before a valid read
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top
// 3x3 sobel gradient magnitude over a raster pixel stream, with a
// controller and a datapath.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top #(
  parameter int MAX_SIZE = sem_pkg::DEFAULT_MAX_SIZE,
  parameter int CW       = $clog2(MAX_SIZE)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sem_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sem_pkg::PIX_W-1:0] pixel_i,
  input  logic                      frame_start_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sem_pkg::PIX_W-1:0] edge_value_o,
  output logic [CW-1:0]             out_column_o,
  output logic [CW-1:0]             out_row_o,
  output logic                      last_of_frame_o
);
  import sem_pkg::*;

  cmd_t    cmd;
  status_t status;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sem_datapath #(
    .MAX_SIZE (MAX_SIZE),
    .CW       (CW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_i         (pixel_i),
    .frame_start_i   (frame_start_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .edge_value_o    (edge_value_o),
    .out_column_o    (out_column_o),
    .out_row_o       (out_row_o),
    .last_of_frame_o (last_of_frame_o)
  );

`ifndef SYNTHESIS
  // one pixel at a time: no second accept right after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous pixel in flight");

  // a result always names an interior centre
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_column_o != '0) && (out_row_o != '0))
    else $error("result for a border position");

  // last result of a frame sits on the diagonal
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_frame_o |-> out_column_o == out_row_o)
    else $error("frame end flagged off the diagonal");
`endif

endmodule
